FILE: design/b2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_pkg: shared types and constants for the byte radix formatter
// Mode codes, radix selection, the sequencer control word and digit lookup.
// ----------------------------------------------------------------------------
package b2a_pkg;

    localparam int VALUE_W = 8;
    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    localparam logic [MODE_W-1:0] MODE_SDEC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UDEC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OCT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LHEX = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UHEX = 3'd4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_UP_A  = 7'h41;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    // Jump conditions of the sequencer.
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_ITEM,
        COND_QUOT_NZ,
        COND_MORE_DIGITS
    } cond_t;

    localparam int PC_W = 2;

    typedef struct packed {
        logic             load;
        logic             extract;
        logic             emit_sign;
        logic             emit_digit;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        begin
            base = upper ? ASCII_UP_A : ASCII_LOW_A;
            if (d < 4'd10)
            begin
                digit_char = ASCII_ZERO + {3'b000, d};
            end
            else
            begin
                digit_char = base + {3'b000, d - 4'd10};
            end
        end
    endfunction

endpackage

FILE: design/b2a_digit_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_digit_div: one radix digit step
// Splits a magnitude into quotient and lowest digit for radix 10, 8 or 16.
// ----------------------------------------------------------------------------
module b2a_digit_div (
    input  logic [b2a_pkg::VALUE_W-1:0] mag,
    input  b2a_pkg::radix_t             radix,
    output logic [b2a_pkg::VALUE_W-1:0] quot,
    output logic [b2a_pkg::DIGIT_W-1:0] rem
);
    import b2a_pkg::*;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   q10;
    logic [VALUE_W-1:0]   r10;

    // Division by ten: 205 / 2048 is exact for every 8-bit magnitude.
    assign prod = mag * 16'd205;
    assign q10  = {3'b000, prod[15:11]};
    assign r10  = mag - ((q10 << 3) + (q10 << 1));

    always_comb
    begin
        case (radix)
            RADIX_DEC:
            begin
                quot = q10;
                rem  = r10[DIGIT_W-1:0];
            end
            RADIX_OCT:
            begin
                quot = mag >> 3;
                rem  = {1'b0, mag[2:0]};
            end
            RADIX_HEX:
            begin
                quot = mag >> 4;
                rem  = mag[3:0];
            end
            default:
            begin
                quot = '0;
                rem  = '0;
            end
        endcase
    end

endmodule

FILE: design/byte_to_ascii_radix_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_to_ascii_radix_formatter: byte to ASCII digit string
// A microcoded sequencer that prints one byte in decimal, octal or hex.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one word: value and mode.
//   Mode 0 is signed decimal, 1 unsigned decimal, 2 octal, 3 lower-case hex
//   and 4 upper-case hex; modes 5 to 7 are taken and produce nothing.
//   The output channel (out_valid/out_ready) gives one ASCII character per
//   word, most significant digit first, with last set on the final one.
//   A negative signed value gives a leading minus sign.
//   An item takes one load step, one extraction step per digit through the
//   single digit divider, one sign step and one output step per digit.
//   The first character is registered by the sign step, or by the first
//   output step when no sign is printed.
//   in_ready is high only in the load step, so one item is worked on at a
//   time. When the receiver stalls, the output register holds its word and
//   the sequencer waits on the emitting step. Reset returns the sequencer
//   to the load step and empties the output register.
// ----------------------------------------------------------------------------
module byte_to_ascii_radix_formatter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [b2a_pkg::VALUE_W-1:0]  value,
    input  logic [b2a_pkg::MODE_W-1:0]   mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [b2a_pkg::CHAR_W-1:0]   char_out,
    output logic                         last
);
    import b2a_pkg::*;

    localparam int STEPS = 2 ** PC_W;
    localparam int STACK = 3;

    // Program: load, extract digits, optional sign, pop digits.
    localparam ctrl_word_t UCODE [STEPS] = '{
        '{load: 1'b1, extract: 1'b0, emit_sign: 1'b0, emit_digit: 1'b0,
          cond: COND_NO_ITEM, target: 2'd0},
        '{load: 1'b0, extract: 1'b1, emit_sign: 1'b0, emit_digit: 1'b0,
          cond: COND_QUOT_NZ, target: 2'd1},
        '{load: 1'b0, extract: 1'b0, emit_sign: 1'b1, emit_digit: 1'b0,
          cond: COND_NEVER, target: 2'd0},
        '{load: 1'b0, extract: 1'b0, emit_sign: 1'b0, emit_digit: 1'b1,
          cond: COND_MORE_DIGITS, target: 2'd3}
    };

    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                upper_reg, upper_next;
    radix_t              radix_reg, radix_next;
    logic [DIGIT_W-1:0]  dig_reg [STACK];
    logic [DIGIT_W-1:0]  dig_next [STACK];
    logic [1:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    ctrl_word_t          cw;
    logic [VALUE_W-1:0]  quot;
    logic [DIGIT_W-1:0]  rem;
    logic                out_free;
    logic                emitting;
    logic                hold;
    logic                take;
    logic                mode_ok;
    logic                jump;

    b2a_digit_div u_div (
        .mag   (mag_reg),
        .radix (radix_reg),
        .quot  (quot),
        .rem   (rem)
    );

    assign cw       = UCODE[pc_reg];
    assign in_ready = cw.load;
    assign take     = in_valid && cw.load;
    assign mode_ok  = (mode <= MODE_UHEX);
    assign out_free = !out_valid_reg || out_ready;
    assign emitting = (cw.emit_sign && neg_reg) || cw.emit_digit;
    assign hold     = emitting && !out_free;

    always_comb
    begin
        case (cw.cond)
            COND_NEVER:       jump = 1'b0;
            COND_NO_ITEM:     jump = !(take && mode_ok);
            COND_QUOT_NZ:     jump = (quot != '0);
            COND_MORE_DIGITS: jump = (cnt_reg > 2'd1);
            default:          jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next        = pc_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        radix_next     = radix_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;

        if (!hold)
        begin
            pc_next = jump ? cw.target : pc_reg + 1'b1;

            if (cw.load && take)
            begin
                neg_next   = (mode == MODE_SDEC) && value[VALUE_W-1];
                mag_next   = ((mode == MODE_SDEC) && value[VALUE_W-1]) ? -value : value;
                upper_next = (mode == MODE_UHEX);
                cnt_next   = 2'd0;
                if (mode == MODE_OCT)
                begin
                    radix_next = RADIX_OCT;
                end
                else if ((mode == MODE_LHEX) || (mode == MODE_UHEX))
                begin
                    radix_next = RADIX_HEX;
                end
                else
                begin
                    radix_next = RADIX_DEC;
                end
            end

            // Digits come out lowest first, so they are pushed on a stack.
            if (cw.extract)
            begin
                mag_next    = quot;
                dig_next[2] = dig_reg[1];
                dig_next[1] = dig_reg[0];
                dig_next[0] = rem;
                cnt_next    = cnt_reg + 2'd1;
            end

            if (cw.emit_sign && neg_reg)
            begin
                out_valid_next = 1'b1;
                char_next      = ASCII_MINUS;
                last_next      = 1'b0;
            end

            if (cw.emit_digit)
            begin
                out_valid_next = 1'b1;
                char_next      = digit_char(dig_reg[0], upper_reg);
                last_next      = (cnt_reg == 2'd1);
                dig_next[0]    = dig_reg[1];
                dig_next[1]    = dig_reg[2];
                cnt_next       = cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        upper_reg <= upper_next;
        radix_reg <= radix_next;
        dig_reg   <= dig_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the byte radix formatter
// A directed set of values and modes is followed by random bursts. A small
// scoreboard predicts the ASCII characters of each accepted word and checks
// every character that leaves, while the receiver stalls in changing styles.
// ----------------------------------------------------------------------------
module tb;

    import b2a_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_SPARSE
    } rx_style_t;

    class char_scoreboard;
        char_word_t pending_chars[$];
        int         errors;
        int         chars_checked;

        function new();
            errors = 0;
            chars_checked = 0;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // Works out the characters of one accepted word and queues them.
        function void note_input(logic [VALUE_W-1:0] v, logic [MODE_W-1:0] m);
            int         radix;
            int         mag;
            int         nd;
            int         rev[4];
            bit         neg;
            string      digit_set;
            char_word_t w;
            begin
                digit_set = "0123456789abcdef";
                nd = 0;
                case (m)
                    MODE_SDEC, MODE_UDEC: radix = 10;
                    MODE_OCT:             radix = 8;
                    MODE_LHEX:            radix = 16;
                    MODE_UHEX:
                    begin
                        radix = 16;
                        digit_set = "0123456789ABCDEF";
                    end
                    default:              return;
                endcase
                neg = (m == MODE_SDEC) && (v > 8'd127);
                mag = neg ? 256 - int'(v) : int'(v);
                do
                begin
                    rev[nd] = mag % radix;
                    nd++;
                    mag = mag / radix;
                end
                while (mag != 0 && nd < 4);
                if (neg)
                begin
                    w.ch = ASCII_MINUS;
                    w.last = 1'b0;
                    pending_chars.push_back(w);
                end
                for (int i = nd - 1; i >= 0; i--)
                begin
                    w.ch = CHAR_W'(digit_set[rev[i]]);
                    w.last = (i == 0);
                    pending_chars.push_back(w);
                end
            end
        endfunction

        function void check_result(logic [CHAR_W-1:0] ch, logic lst);
            char_word_t w;
            begin
                chars_checked++;
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected word: char_out %h last %b", ch, lst);
                    errors++;
                    return;
                end
                w = pending_chars.pop_front();
                if (ch !== w.ch)
                begin
                    $error("char_out mismatch: expected %h, actual %h", w.ch, ch);
                    errors++;
                end
                if (lst !== w.last)
                begin
                    $error("last mismatch: expected %b, actual %b", w.last, lst);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] value = '0;
    logic [MODE_W-1:0]  mode = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  char_out;
    logic               last;

    char_scoreboard sb;
    int             words_taken = 0;
    int             words_ignored = 0;
    rx_style_t      rx_style = RX_ALWAYS;
    int             rx_left = 0;
    logic [1:0]     rx_tick = '0;

    byte_to_ascii_radix_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Both handshakes are observed on the edge, before any driven change lands.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_input(value, mode);
            words_taken++;
            if (mode > MODE_UHEX)
            begin
                words_ignored++;
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(char_out, last);
        end
    end

    // The receiver switches between stall styles, picked at random.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 2'd1;
        if (rx_left == 0)
        begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 80);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_ALWAYS:      out_ready <= 1'b1;
            RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: out_ready <= (rx_tick == 2'd0);
            default:        out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Holds one word on the input until it is taken; valid stays high afterward.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic [MODE_W-1:0] m);
        in_valid <= 1'b1;
        value <= v;
        mode <= m;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] corners[4];
        begin
            corners = '{8'd0, 8'd127, 8'd128, 8'd255};
            if ($urandom_range(0, 9) == 0)
            begin
                return corners[2'($urandom_range(0, 3))];
            end
            return VALUE_W'($urandom_range(0, 255));
        end
    endfunction

    initial
    begin
        int  real_words;
        int  burst;
        bit  drained_once;
        logic [MODE_W-1:0] m;
        sb = new();
        real_words = 0;
        drained_once = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of each mode (upper hex without zero), the most negative byte, unused modes.
        send_word(8'd0,   MODE_SDEC);
        send_word(8'd127, MODE_SDEC);
        send_word(8'd128, MODE_SDEC);
        send_word(8'd255, MODE_SDEC);
        send_word(8'd1,   MODE_SDEC);
        send_word(8'd156, MODE_SDEC);
        idle_input(3);
        send_word(8'd0,   MODE_UDEC);
        send_word(8'd9,   MODE_UDEC);
        send_word(8'd10,  MODE_UDEC);
        send_word(8'd255, MODE_UDEC);
        send_word(8'd0,   MODE_OCT);
        send_word(8'd7,   MODE_OCT);
        send_word(8'd8,   MODE_OCT);
        send_word(8'd255, MODE_OCT);
        idle_input(5);
        send_word(8'd0,   MODE_LHEX);
        send_word(8'd171, MODE_LHEX);
        send_word(8'd255, MODE_LHEX);
        send_word(8'd15,  MODE_UHEX);
        send_word(8'd16,  MODE_UHEX);
        send_word(8'd255, MODE_UHEX);
        send_word(8'd200, 3'd5);
        send_word(8'd85,  3'd6);
        send_word(8'd170, 3'd7);
        send_word(8'd42,  MODE_UHEX);

        // Random bursts; words in unused modes are noise and are not counted.
        while (real_words < 225)
        begin
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    m = MODE_W'($urandom_range(5, 7));
                end
                else
                begin
                    m = MODE_W'($urandom_range(0, 4));
                    real_words++;
                end
                send_word(pick_value(), m);
            end
            if (!drained_once && real_words >= 110)
            begin
                drained_once = 1'b1;
                in_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
                @(posedge clk);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                idle_input($urandom_range(1, 12));
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Covered %0d input words (%0d in unused modes) and checked %0d characters.",
                 words_taken, words_ignored, sb.chars_checked);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
